// File: sv/level_monitor_alert_blinker_unit_macros.svh
// ----------------------------------------------------------------------------
// level_monitor_alert_blinker_unit_macros
// Assertion macros for the level monitor / alert blinker unit.
// ----------------------------------------------------------------------------
`ifndef LEVEL_MONITOR_ALERT_BLINKER_UNIT_MACROS_SVH
`define LEVEL_MONITOR_ALERT_BLINKER_UNIT_MACROS_SVH

// Generic clocked property, disabled during reset.
`define LMAB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lmab assertion failed");

// A stalled channel keeps its signal unchanged.
`define LMAB_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
    else $error("lmab stalled signal changed");

`endif

// File: sv/lmab_pkg.sv
// ----------------------------------------------------------------------------
// lmab_pkg
// Shared types and constants for the level monitor / alert blinker unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmab_pkg;

  localparam int LEVEL_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int NIBBLE_W   = 4;
  localparam int PERIOD_W   = 16;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int COUNTER_BITS_DEF = 16;

  localparam logic [LEVEL_W-1:0]  LOW_THRESHOLD_RST = 12'd616;
  localparam logic [LEVEL_W-1:0]  ALARM_LEVEL_RST   = 12'd1859;
  localparam logic [BYTE_W-1:0]   ALERT_CODE_RST    = 8'hA5;
  localparam logic [BYTE_W-1:0]   CLEAR_CODE_RST    = 8'h00;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST   = 16'd1500;
  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST  = 16'd500;

  // Item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_THRESHOLD = 3'd0,
    REG_ALARM_LEVEL   = 3'd1,
    REG_ALERT_CODE    = 3'd2,
    REG_CLEAR_CODE    = 3'd3,
    REG_LONG_PERIOD   = 3'd4,
    REG_SHORT_PERIOD  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  low_threshold;
    logic [LEVEL_W-1:0]  alarm_level;
    logic [BYTE_W-1:0]   alert_code;
    logic [BYTE_W-1:0]   clear_code;
    logic [PERIOD_W-1:0] long_period;
    logic [PERIOD_W-1:0] short_period;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic               level_valid;
    logic [LEVEL_W-1:0] level;
    logic               send_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic               led;
  } res_t;

endpackage

`default_nettype wire

// File: sv/lmab_if.sv
// ----------------------------------------------------------------------------
// lmab_if
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lmab_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lmab_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, mode, data_byte, input ready);
  modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface lmab_out_if;
  logic                         valid;
  logic                         ready;
  logic                         level_valid;
  logic [lmab_pkg::LEVEL_W-1:0] level;
  logic                         send_valid;
  logic [lmab_pkg::BYTE_W-1:0]  send_byte;
  logic                         led;
  modport source (output valid, level_valid, level, send_valid, send_byte, led,
                  input ready);
  modport sink   (input valid, level_valid, level, send_valid, send_byte, led,
                  output ready);
endinterface

interface lmab_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lmab_pkg::REG_IDX_W-1:0]  index;
  logic [lmab_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/lmab_cfg_regs.sv
// ----------------------------------------------------------------------------
// lmab_cfg_regs
// Register bank for thresholds, codes and blink periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmab_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  lmab_cfg_if.sink      cfg_ch,
  output lmab_pkg::cfg_t cfg
);

  lmab_pkg::cfg_t regs;
  lmab_pkg::cfg_t regs_next;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = regs;

  always_comb begin
    regs_next = regs;
    if (cfg_ch.valid) begin
      case (lmab_pkg::reg_idx_t'(cfg_ch.index))
        lmab_pkg::REG_LOW_THRESHOLD:
          regs_next.low_threshold = cfg_ch.data[lmab_pkg::LEVEL_W-1:0];
        lmab_pkg::REG_ALARM_LEVEL:
          regs_next.alarm_level   = cfg_ch.data[lmab_pkg::LEVEL_W-1:0];
        lmab_pkg::REG_ALERT_CODE:
          regs_next.alert_code    = cfg_ch.data[lmab_pkg::BYTE_W-1:0];
        lmab_pkg::REG_CLEAR_CODE:
          regs_next.clear_code    = cfg_ch.data[lmab_pkg::BYTE_W-1:0];
        lmab_pkg::REG_LONG_PERIOD:
          regs_next.long_period   = cfg_ch.data[lmab_pkg::PERIOD_W-1:0];
        lmab_pkg::REG_SHORT_PERIOD:
          regs_next.short_period  = cfg_ch.data[lmab_pkg::PERIOD_W-1:0];
        default: ; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_threshold <= lmab_pkg::LOW_THRESHOLD_RST;
      regs.alarm_level   <= lmab_pkg::ALARM_LEVEL_RST;
      regs.alert_code    <= lmab_pkg::ALERT_CODE_RST;
      regs.clear_code    <= lmab_pkg::CLEAR_CODE_RST;
      regs.long_period   <= lmab_pkg::LONG_PERIOD_RST;
      regs.short_period  <= lmab_pkg::SHORT_PERIOD_RST;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/lmab_state.sv
// ----------------------------------------------------------------------------
// lmab_state
// Monitor state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmab_state #(
  parameter int COUNTER_BITS = lmab_pkg::COUNTER_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire lmab_pkg::item_t item,
  input  wire lmab_pkg::cfg_t  cfg,
  output lmab_pkg::res_t       res
);

  localparam int CMP_W = (COUNTER_BITS > lmab_pkg::PERIOD_W) ? COUNTER_BITS
                                                              : lmab_pkg::PERIOD_W;

  logic                            byte_phase,    byte_phase_next;
  logic [lmab_pkg::NIBBLE_W-1:0]   high_nibble,   high_nibble_next;
  logic                            above_seen,    above_seen_next;
  logic                            alert_sent,    alert_sent_next;
  logic                            alarm_armed,   alarm_armed_next;
  logic                            blink_enabled, blink_enabled_next;
  logic                            led_state,     led_state_next;
  logic [COUNTER_BITS-1:0]         tick_count,    tick_count_next;
  logic                            short_phase,   short_phase_next;

  logic [lmab_pkg::LEVEL_W-1:0]    lvl;
  logic [lmab_pkg::PERIOD_W-1:0]   cmp;
  logic [COUNTER_BITS-1:0]         tick_inc;
  logic                            period_end;

  assign lvl        = {high_nibble, item.data_byte};
  assign cmp        = short_phase ? cfg.short_period : cfg.long_period;
  assign tick_inc   = tick_count + COUNTER_BITS'(1);
  assign period_end = CMP_W'(tick_inc) >= CMP_W'(cmp);

  always_comb begin
    byte_phase_next    = byte_phase;
    high_nibble_next   = high_nibble;
    above_seen_next    = above_seen;
    alert_sent_next    = alert_sent;
    alarm_armed_next   = alarm_armed;
    blink_enabled_next = blink_enabled;
    led_state_next     = led_state;
    tick_count_next    = tick_count;
    short_phase_next   = short_phase;
    res                = '0;

    if (item.mode == lmab_pkg::MODE_BYTE) begin
      if (!byte_phase) begin
        high_nibble_next = item.data_byte[lmab_pkg::NIBBLE_W-1:0];
        byte_phase_next  = 1'b1;
      end else begin
        byte_phase_next = 1'b0;
        res.level_valid = 1'b1;
        res.level       = lvl;
        if (lvl < cfg.low_threshold) begin
          if (above_seen) begin
            res.send_valid  = 1'b1;
            res.send_byte   = cfg.alert_code;
            above_seen_next = 1'b0;
            alert_sent_next = 1'b1;
          end
        end else begin
          above_seen_next = 1'b1;
          if (alert_sent) begin
            res.send_valid  = 1'b1;
            res.send_byte   = cfg.clear_code;
            alert_sent_next = 1'b0;
          end
        end
        if (lvl == cfg.alarm_level) begin
          if (alarm_armed) begin
            blink_enabled_next = 1'b1;
            alarm_armed_next   = 1'b0;
          end
        end else if (lvl < cfg.alarm_level) begin
          alarm_armed_next   = 1'b1;
          blink_enabled_next = 1'b0;
          led_state_next     = 1'b0;
          tick_count_next    = '0;
        end
      end
    end else begin
      if (period_end) begin
        tick_count_next = '0;
        if (blink_enabled) begin
          led_state_next   = ~led_state;
          short_phase_next = ~short_phase;
        end
      end else begin
        tick_count_next = tick_inc;
      end
    end

    res.led = led_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 1'b0;
      high_nibble   <= '0;
      above_seen    <= 1'b0;
      alert_sent    <= 1'b0;
      alarm_armed   <= 1'b0;
      blink_enabled <= 1'b0;
      led_state     <= 1'b0;
      tick_count    <= '0;
      short_phase   <= 1'b0;
    end else if (advance) begin
      byte_phase    <= byte_phase_next;
      high_nibble   <= high_nibble_next;
      above_seen    <= above_seen_next;
      alert_sent    <= alert_sent_next;
      alarm_armed   <= alarm_armed_next;
      blink_enabled <= blink_enabled_next;
      led_state     <= led_state_next;
      tick_count    <= tick_count_next;
      short_phase   <= short_phase_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/level_monitor_alert_blinker_unit.sv
// Path: input register, then result register; a stall may hold it in between.
// Throughput: one item per cycle while out_ch.ready is high; the input register
//   refills in the same cycle it hands its item to the result register.
// Stalls: only a held result register (out_ch.ready low) stops the input side.
// Reset: synchronous, active high; clears all monitor state, both valid flags,
//   and loads the register bank with its default thresholds, codes and periods.
// ----------------------------------------------------------------------------
// level_monitor_alert_blinker_unit
// Assembles 12-bit levels from byte pairs, sends alert/clear codes on
// threshold crossings and blinks an LED from timer ticks on an armed alarm hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module level_monitor_alert_blinker_unit #(
  parameter int COUNTER_BITS = lmab_pkg::COUNTER_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  lmab_in_if.sink   in_ch,
  lmab_out_if.source out_ch,
  lmab_cfg_if.sink  cfg_ch
);

  // Input register: holds one accepted item until the state update runs.
  logic            in_valid;
  lmab_pkg::item_t in_item;

  // Result register.
  logic            out_valid;
  lmab_pkg::res_t  out_res;

  lmab_pkg::cfg_t  cfg;
  lmab_pkg::res_t  res;
  logic            advance;

  // The item in the input register is processed (state committed, result
  // captured) whenever the result register is empty or being drained.
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item.mode      <= in_ch.mode;
      in_item.data_byte <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  lmab_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Level checks and tick counter: one pass per item.
  lmab_state #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.level_valid = out_res.level_valid;
  assign out_ch.level       = out_res.level;
  assign out_ch.send_valid  = out_res.send_valid;
  assign out_ch.send_byte   = out_res.send_byte;
  assign out_ch.led         = out_res.led;

endmodule

`default_nettype wire

// File: sv/lmab_checker.sv
// ----------------------------------------------------------------------------
// lmab_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "level_monitor_alert_blinker_unit_macros.svh"

module lmab_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         level_valid,
  input wire logic [lmab_pkg::LEVEL_W-1:0] level,
  input wire logic                         send_valid,
  input wire logic [lmab_pkg::BYTE_W-1:0]  send_byte
);

  // Valid held while the sink stalls.
  `LMAB_ASSERT_HOLD(a_out_hold, clk, rst, out_valid, out_ready, out_valid)

  // A code is only sent on the item that completes a level.
  `LMAB_ASSERT(a_send_needs_level, clk, rst, (out_valid && send_valid) |-> level_valid)

  // Fields without their valid flag read as zero.
  `LMAB_ASSERT(a_level_zero, clk, rst, (out_valid && !level_valid) |-> (level == '0))
  `LMAB_ASSERT(a_send_zero, clk, rst, (out_valid && !send_valid) |-> (send_byte == '0))

  // Nothing comes out right after reset.
  `LMAB_ASSERT(a_reset_empty, clk, rst, $past(rst) |-> !out_valid)

endmodule

bind level_monitor_alert_blinker_unit lmab_checker u_lmab_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .level_valid (out_ch.level_valid),
  .level       (out_ch.level),
  .send_valid  (out_ch.send_valid),
  .send_byte   (out_ch.send_byte)
);

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for level_monitor_alert_blinker_unit. A directed table
// covers reset values, field extremes, threshold and alarm edges, period
// extremes and writes to unused register slots. Randomized phases follow,
// each with a fresh register setting. Every result item is compared field
// by field with a hand-typed result or an in-bench model of the monitor.
// Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lmab_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int MAX_PRINTS    = 40;

  // Register slots past the end of the bank; writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed step: an item (optionally with a hand-typed result) or a
  // register write done with the block idle.
  typedef struct packed {
    row_kind_t             kind;
    logic                  mode;
    logic [BYTE_W-1:0]     data;
    logic [REG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    res_t                  want;
  } dir_row_t;

  localparam res_t QUIET = '0;

  localparam dir_row_t DIRECTED [32] = '{
    // reset state: tick and first byte give an empty result, LED off
    '{ROW_ITEM, MODE_TICK, 8'h00, '0, '0, 1'b1, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'hFF, '0, '0, 1'b1, QUIET},
    // full-scale level: above threshold, no code yet
    '{ROW_ITEM, MODE_BYTE, 8'hFF, '0, '0, 1'b1, '{1'b1, 12'hFFF, 1'b0, 8'h00, 1'b0}},
    // drop to zero: alert code once
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b1, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b1, '{1'b1, 12'h000, 1'b1, 8'hA5, 1'b0}},
    // exactly at threshold counts as recovered: clear code
    '{ROW_ITEM, MODE_BYTE, 8'hF2, '0, '0, 1'b1, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h68, '0, '0, 1'b1, '{1'b1, 12'h268, 1'b1, 8'h00, 1'b0}},
    // one below threshold: alert again
    '{ROW_ITEM, MODE_BYTE, 8'h02, '0, '0, 1'b1, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h67, '0, '0, 1'b1, '{1'b1, 12'h267, 1'b1, 8'hA5, 1'b0}},
    // exact alarm level after being below: blinker on, plus clear code
    '{ROW_ITEM, MODE_BYTE, 8'h07, '0, '0, 1'b1, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h43, '0, '0, 1'b1, '{1'b1, 12'h743, 1'b1, 8'h00, 1'b0}},
    // short periods so the LED visibly alternates
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_LONG_PERIOD,  16'd2, 1'b0, QUIET},
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_SHORT_PERIOD, 16'd1, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'h00, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'hFF, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'h00, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'h5A, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'hA5, '0, '0, 1'b0, QUIET},
    // alarm level again while not armed: no change
    '{ROW_ITEM, MODE_BYTE, 8'h07, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h43, '0, '0, 1'b0, QUIET},
    // upper nibble of the first byte is dropped
    '{ROW_ITEM, MODE_BYTE, 8'h5A, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b0, QUIET},
    // below alarm: blinker off, LED off, counter cleared
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b0, QUIET},
    // zero periods end a period on every tick
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_LONG_PERIOD,  16'd0, 1'b0, QUIET},
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_SHORT_PERIOD, 16'd0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'h00, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_TICK, 8'h00, '0, '0, 1'b0, QUIET},
    // unused register slots: writes ignored
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_SPARE_6, 16'hFFFF, 1'b0, QUIET},
    '{ROW_CFG,  MODE_BYTE, 8'h00, REG_SPARE_7, 16'hFFFF, 1'b0, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b0, QUIET},
    '{ROW_ITEM, MODE_BYTE, 8'h00, '0, '0, 1'b0, QUIET}
  };

  logic clk;
  logic rst;

  lmab_in_if  in_ch();
  lmab_out_if out_ch();
  lmab_cfg_if cfg_ch();

  level_monitor_alert_blinker_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor model: register copy and state
  // --------------------------------------------------------------------------
  cfg_t                        regs;
  logic                        pair_open;   // first byte of a pair taken
  logic [NIBBLE_W-1:0]         hi_nib;
  logic                        above_seen;
  logic                        alert_out;   // alert sent, clear pending
  logic                        armed;
  logic                        blinking;
  logic                        led_on;
  logic                        in_short;
  logic [COUNTER_BITS_DEF-1:0] tick_cnt;

  res_t due_reports[$];   // result items still owed by the block

  int unsigned err_count  = 0;
  int unsigned item_count = 0;
  int unsigned reg_writes = 0;
  int unsigned levels_seen = 0;
  int unsigned codes_seen  = 0;
  int unsigned led_flips   = 0;
  int unsigned cycle_cnt   = 0;
  int          stall_left  = 0;
  bit          src_idle    = 1'b0;
  bit          sink_idle   = 1'b0;
  logic        led_prev    = 1'b0;

  task automatic reset_model();
    regs = '{LOW_THRESHOLD_RST, ALARM_LEVEL_RST, ALERT_CODE_RST, CLEAR_CODE_RST,
             LONG_PERIOD_RST, SHORT_PERIOD_RST};
    pair_open  = 1'b0;
    hi_nib     = '0;
    above_seen = 1'b0;
    alert_out  = 1'b0;
    armed      = 1'b0;
    blinking   = 1'b0;
    led_on     = 1'b0;
    in_short   = 1'b0;
    tick_cnt   = '0;
  endtask

  task automatic apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LOW_THRESHOLD: regs.low_threshold = val[LEVEL_W-1:0];
      REG_ALARM_LEVEL:   regs.alarm_level   = val[LEVEL_W-1:0];
      REG_ALERT_CODE:    regs.alert_code    = val[BYTE_W-1:0];
      REG_CLEAR_CODE:    regs.clear_code    = val[BYTE_W-1:0];
      REG_LONG_PERIOD:   regs.long_period   = val[PERIOD_W-1:0];
      REG_SHORT_PERIOD:  regs.short_period  = val[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // Advance the model by one item and return the result item it owes.
  function automatic res_t advance_monitor(input logic m, input logic [BYTE_W-1:0] b);
    res_t                        r;
    logic [LEVEL_W-1:0]          lvl;
    logic [PERIOD_W-1:0]         cmp;
    logic [COUNTER_BITS_DEF-1:0] nxt;
    r = '0;
    if (m == MODE_BYTE) begin
      if (!pair_open) begin
        hi_nib    = b[NIBBLE_W-1:0];
        pair_open = 1'b1;
      end else begin
        pair_open     = 1'b0;
        lvl           = {hi_nib, b};
        r.level_valid = 1'b1;
        r.level       = lvl;
        if (lvl < regs.low_threshold) begin
          if (above_seen) begin
            r.send_valid = 1'b1;
            r.send_byte  = regs.alert_code;
            above_seen   = 1'b0;
            alert_out    = 1'b1;
          end
        end else begin
          above_seen = 1'b1;
          if (alert_out) begin
            r.send_valid = 1'b1;
            r.send_byte  = regs.clear_code;
            alert_out    = 1'b0;
          end
        end
        if (lvl == regs.alarm_level) begin
          if (armed) begin
            blinking = 1'b1;
            armed    = 1'b0;
          end
        end else if (lvl < regs.alarm_level) begin
          // short phase is left as it is
          armed    = 1'b1;
          blinking = 1'b0;
          led_on   = 1'b0;
          tick_cnt = '0;
        end
      end
    end else begin
      cmp = in_short ? regs.short_period : regs.long_period;
      nxt = tick_cnt + 1'b1;
      if (nxt >= cmp) begin
        tick_cnt = '0;
        if (blinking) begin
          led_on   = ~led_on;
          in_short = ~in_short;
        end
      end else begin
        tick_cnt = nxt;
      end
    end
    r.led = led_on;
    return r;
  endfunction

  task automatic flag(input string what, input int unsigned got, input int unsigned want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t  mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Item source
  // --------------------------------------------------------------------------
  // Leaves valid high after the accept so a zero gap stays back to back.
  task automatic send_item(input logic m, input logic [BYTE_W-1:0] d,
                           input logic use_want, input res_t want);
    int   gap;
    res_t owed;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= d;
    do @(posedge clk); while (!in_ch.ready);
    owed = advance_monitor(m, d);
    due_reports.push_back(use_want ? want : owed);
    item_count++;
  endtask

  // Stop sending and wait until every owed result item has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_level(input logic [LEVEL_W-1:0] lvl);
    logic [NIBBLE_W-1:0] junk;
    junk = NIBBLE_W'($urandom_range(0, 15));
    send_item(MODE_BYTE, {junk, lvl[11:8]}, 1'b0, QUIET);
    send_item(MODE_BYTE, lvl[7:0], 1'b0, QUIET);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, QUIET);
  endtask

  // Levels cluster on the threshold and alarm edges.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return LEVEL_W'($urandom_range(0, 4095));
      1:       return regs.low_threshold - 1'b1;
      2:       return regs.low_threshold;
      3:       return regs.alarm_level;
      4:       return regs.alarm_level - 1'b1;
      5:       return '0;
      6:       return '1;
      default: return regs.alarm_level + 1'b1;
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PERIOD_W'($urandom_range(10, 40));
      default: return PERIOD_W'($urandom_range(1, 5));
    endcase
  endfunction

  // Phase 0 and 1 hit the register extremes, the rest are random. Unused
  // upper data bits carry noise; the block must drop them.
  task automatic configure_phase(input int p);
    logic [LEVEL_W-1:0]  lo;
    logic [LEVEL_W-1:0]  al;
    logic [BYTE_W-1:0]   ac;
    logic [BYTE_W-1:0]   cc;
    logic [PERIOD_W-1:0] lp;
    logic [PERIOD_W-1:0] sp;
    logic [3:0]          j4a;
    logic [3:0]          j4b;
    logic [7:0]          j8a;
    logic [7:0]          j8b;
    case (p)
      0: begin
        lo = '0; al = '1; ac = '1; cc = '0; lp = 16'd1; sp = '1;
      end
      1: begin
        lo = '1; al = '0; ac = '0; cc = '1; lp = '1; sp = 16'd1;
      end
      default: begin
        lo = LEVEL_W'($urandom_range(0, 4095));
        al = LEVEL_W'($urandom_range(1, 4095));
        ac = BYTE_W'($urandom_range(0, 255));
        cc = BYTE_W'($urandom_range(0, 255));
        lp = pick_period();
        sp = pick_period();
      end
    endcase
    j4a = 4'($urandom_range(0, 15));
    j4b = 4'($urandom_range(0, 15));
    j8a = 8'($urandom_range(0, 255));
    j8b = 8'($urandom_range(0, 255));
    settle();
    write_reg(REG_LOW_THRESHOLD, {j4a, lo});
    write_reg(REG_ALARM_LEVEL,   {j4b, al});
    write_reg(REG_ALERT_CODE,    {j8a, ac});
    write_reg(REG_CLEAR_CODE,    {j8b, cc});
    write_reg(REG_LONG_PERIOD,   lp);
    write_reg(REG_SHORT_PERIOD,  sp);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6,
                CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  // --------------------------------------------------------------------------
  // Result sink and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.level_valid, out_ch.level, out_ch.send_valid, out_ch.send_byte,
               out_ch.led};
        if (due_reports.size() == 0) begin
          flag("result item with nothing outstanding", 32'(got), 0);
        end else begin
          want = due_reports.pop_front();
          if (got.level_valid !== want.level_valid)
            flag("level_valid", 32'(got.level_valid), 32'(want.level_valid));
          if (got.level !== want.level)
            flag("level", 32'(got.level), 32'(want.level));
          if (got.send_valid !== want.send_valid)
            flag("send_valid", 32'(got.send_valid), 32'(want.send_valid));
          if (got.send_byte !== want.send_byte)
            flag("send_byte", 32'(got.send_byte), 32'(want.send_byte));
          if (got.led !== want.led)
            flag("led", 32'(got.led), 32'(want.led));
        end
        if (got.level_valid === 1'b1) levels_seen++;
        if (got.send_valid === 1'b1) codes_seen++;
        if (got.led !== led_prev) led_flips++;
        led_prev = got.led;
        stall_left = sink_idle ? $urandom_range(0, 7) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t  watchdog expired, %0d result items outstanding", $time,
               due_reports.size());
      $display("[level_monitor_alert_blinker_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned start;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_BYTE;
    in_ch.data_byte  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_LOW_THRESHOLD;
    cfg_ch.data      = '0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[i].reg_sel, DIRECTED[i].value);
      end else begin
        send_item(DIRECTED[i].mode, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random phases: mostly byte pairs and tick bursts, some arm-and-hit
    // sequences to reach the blinker, some stray items that can break pairing.
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      src_idle  = ($urandom_range(0, 2) != 0);
      sink_idle = ($urandom_range(0, 2) != 0);
      start = item_count;
      while (item_count - start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_level(pick_level());
          5, 6, 7:       send_ticks($urandom_range(1, 12));
          8: begin
            send_level(regs.alarm_level - 1'b1);
            send_level(regs.alarm_level);
            send_ticks($urandom_range(4, 20));
          end
          default: send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                             1'b0, QUIET);
        endcase
        // occasional full drain in mid-phase
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    $display("Run: %0d items, %0d register writes across %0d phases after the directed table.",
             item_count, reg_writes, PHASES);
    $display("Seen: %0d levels, %0d alert/clear bytes, %0d LED changes, %0d mismatches.",
             levels_seen, codes_seen, led_flips, err_count);
    if (err_count == 0) begin
      $display("[level_monitor_alert_blinker_unit] OK");
    end else begin
      $display("[level_monitor_alert_blinker_unit] ERROR");
    end
    $finish;
  end

endmodule
